### sv/gdda_pkg.sv
package gdda_pkg;

   localparam int BASE_YEAR = 1900;
   localparam int YEAR_SPAN = 256;
   localparam int LAST_YEAR = BASE_YEAR + YEAR_SPAN - 1;
   localparam int PREV_YEAR = BASE_YEAR - 1;

   localparam int LEAPS_TO_LAST = LAST_YEAR / 4 - LAST_YEAR / 100 + LAST_YEAR / 400;
   localparam int LEAPS_TO_PREV = PREV_YEAR / 4 - PREV_YEAR / 100 + PREV_YEAR / 400;
   localparam int TOTAL_DAYS    = YEAR_SPAN * 365 + LEAPS_TO_LAST - LEAPS_TO_PREV;

   localparam int SERIAL_W = $clog2(TOTAL_DAYS + 1);
   localparam int ACC_W    = ((SERIAL_W + 1 > 18) ? SERIAL_W + 1 : 18) + 1;

   localparam int BASE_MOD100 = BASE_YEAR % 100;
   localparam int BASE_MOD400 = BASE_YEAR % 400;

   typedef enum logic [1:0] {
      RES_INVALID = 2'd0,
      RES_OUT     = 2'd1,
      RES_OK      = 2'd2
   } res_kind_type;

   typedef struct packed {
      logic         load;
      logic         year_step;
      logic         month_step;
      logic         month_last;
      logic         add_offset;
      logic         shift_year;
      logic         shift_month;
      logic         finish;
      res_kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic range_ok;
      logic year_hit;
      logic month_hit;
      logic day_fits;
      logic serial_ok;
      logic year_more;
      logic month_more;
   } status_type;

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] r;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
         4'd2: r = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
      logic [3:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 4'd7) s = s - 4'd7;
      return s[2:0];
   endfunction

   function automatic logic [2:0] day_mod7(input logic [4:0] d);
      logic [4:0] v;
      v = d - 5'd1;
      if (v >= 5'd28) v = v - 5'd28;
      if (v >= 5'd14) v = v - 5'd14;
      if (v >= 5'd7) v = v - 5'd7;
      return v[2:0];
   endfunction

endpackage

### sv/gdda_ctrl.sv
module gdda_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  gdda_pkg::status_type status,
   output gdda_pkg::cmd_type    cmd
);
   import gdda_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE        = 8'b00000001,
      ST_VALIDATE    = 8'b00000010,
      ST_YEAR_SCAN   = 8'b00000100,
      ST_MONTH_SCAN  = 8'b00001000,
      ST_OFFSET      = 8'b00010000,
      ST_RANGE       = 8'b00100000,
      ST_SHIFT_YEAR  = 8'b01000000,
      ST_SHIFT_MONTH = 8'b10000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.kind = RES_INVALID;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_VALIDATE;
            end
         end
         ST_VALIDATE: begin
            if (status.range_ok) begin
               state_in = ST_YEAR_SCAN;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_YEAR_SCAN: begin
            if (status.year_hit) begin
               state_in = ST_MONTH_SCAN;
            end else begin
               cmd.year_step = 1'b1;
            end
         end
         ST_MONTH_SCAN: begin
            if (!status.month_hit) begin
               cmd.month_step = 1'b1;
            end else if (status.day_fits) begin
               cmd.month_last = 1'b1;
               state_in       = ST_OFFSET;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_OFFSET: begin
            cmd.add_offset = 1'b1;
            state_in       = ST_RANGE;
         end
         ST_RANGE: begin
            if (status.serial_ok) begin
               state_in = ST_SHIFT_YEAR;
            end else begin
               cmd.finish = 1'b1;
               cmd.kind   = RES_OUT;
               state_in   = ST_IDLE;
            end
         end
         ST_SHIFT_YEAR: begin
            if (status.year_more) begin
               cmd.shift_year = 1'b1;
            end else begin
               state_in = ST_SHIFT_MONTH;
            end
         end
         ST_SHIFT_MONTH: begin
            if (status.month_more) begin
               cmd.shift_month = 1'b1;
            end else begin
               cmd.finish = 1'b1;
               cmd.kind   = RES_OK;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_start_validates: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_VALIDATE))
      else $error("accepted transaction did not enter validation");

   a_finish_idles: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (state_ff == ST_IDLE))
      else $error("controller did not return to idle after a result");
`endif

endmodule

### sv/gdda_datapath.sv
module gdda_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  gdda_pkg::cmd_type    cmd,
   output gdda_pkg::status_type status,
   input  logic [4:0]           req_day_of_month,
   input  logic [3:0]           req_month,
   input  logic [15:0]          req_year,
   input  logic signed [17:0]   req_offset_days,
   output logic                 rsp_strobe,
   output logic                 rsp_date_valid,
   output logic [16:0]          rsp_day_serial,
   output logic [2:0]           rsp_weekday,
   output logic [4:0]           rsp_shifted_day,
   output logic [3:0]           rsp_shifted_month,
   output logic [15:0]          rsp_shifted_year,
   output logic                 rsp_out_of_range
);
   import gdda_pkg::*;

   localparam logic signed [ACC_W-1:0] ACC_ONE   = ACC_W'(1);
   localparam logic signed [ACC_W-1:0] ACC_TOTAL = ACC_W'(TOTAL_DAYS);

   logic [4:0]              day_ff;
   logic [3:0]              month_ff;
   logic [15:0]             year_ff;
   logic signed [17:0]      offset_ff;
   logic [15:0]             yr_ff, yr_in;
   logic [6:0]              c100_ff, c100_in;
   logic [8:0]              c400_ff, c400_in;
   logic [3:0]              mon_ff, mon_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] serial_ff, serial_in;
   logic [2:0]              wk_ff, wk_in;

   logic                    rsp_strobe_ff;
   logic                    rsp_date_valid_ff;
   logic [16:0]             rsp_day_serial_ff;
   logic [2:0]              rsp_weekday_ff;
   logic [4:0]              rsp_shifted_day_ff;
   logic [3:0]              rsp_shifted_month_ff;
   logic [15:0]             rsp_shifted_year_ff;
   logic                    rsp_out_of_range_ff;

   logic                    leap;
   logic [8:0]              yd;
   logic [4:0]              md;
   logic [4:0]              md_excess;
   logic signed [ACC_W-1:0] yd_ext;
   logic signed [ACC_W-1:0] md_ext;
   logic signed [ACC_W-1:0] day_ext;
   logic signed [ACC_W-1:0] off_ext;
   logic                    advance_year;

   assign leap      = (yr_ff[1:0] == 2'b00) && ((c100_ff != 7'd0) || (c400_ff == 9'd0));
   assign yd        = leap ? 9'd366 : 9'd365;
   assign md        = month_days(mon_ff, leap);
   assign md_excess = md - 5'd28;
   assign yd_ext    = ACC_W'(yd);
   assign md_ext    = ACC_W'(md);
   assign day_ext   = ACC_W'(day_ff);
   assign off_ext   = {{(ACC_W - 18){offset_ff[17]}}, offset_ff};

   assign status.range_ok   = (year_ff >= 16'(BASE_YEAR)) && (year_ff <= 16'(LAST_YEAR)) &&
                              (month_ff >= 4'd1) && (month_ff <= 4'd12) &&
                              (day_ff != 5'd0);
   assign status.year_hit   = (yr_ff == year_ff);
   assign status.month_hit  = (mon_ff == month_ff);
   assign status.day_fits   = (day_ff <= md);
   assign status.serial_ok  = (acc_ff >= ACC_ONE) && (acc_ff <= ACC_TOTAL);
   assign status.year_more  = (acc_ff > yd_ext);
   assign status.month_more = (mon_ff < 4'd12) && (acc_ff > md_ext);

   assign advance_year = cmd.year_step || cmd.shift_year;

   always_comb begin
      yr_in     = yr_ff;
      c100_in   = c100_ff;
      c400_in   = c400_ff;
      mon_in    = mon_ff;
      acc_in    = acc_ff;
      serial_in = serial_ff;
      wk_in     = wk_ff;
      if (cmd.load || cmd.add_offset) begin
         yr_in   = 16'(BASE_YEAR);
         c100_in = 7'(BASE_MOD100);
         c400_in = 9'(BASE_MOD400);
         mon_in  = 4'd1;
      end
      if (advance_year) begin
         yr_in   = yr_ff + 16'd1;
         c100_in = (c100_ff == 7'd99) ? 7'd0 : c100_ff + 7'd1;
         c400_in = (c400_ff == 9'd399) ? 9'd0 : c400_ff + 9'd1;
      end
      if (cmd.month_step || cmd.shift_month) begin
         mon_in = mon_ff + 4'd1;
      end
      if (cmd.load) begin
         acc_in = '0;
         wk_in  = 3'd0;
      end
      if (cmd.year_step) begin
         acc_in = acc_ff + yd_ext;
         wk_in  = add_mod7(wk_ff, leap ? 3'd2 : 3'd1);
      end
      if (cmd.month_step) begin
         acc_in = acc_ff + md_ext;
         wk_in  = add_mod7(wk_ff, md_excess[2:0]);
      end
      if (cmd.month_last) begin
         acc_in = acc_ff + day_ext;
         wk_in  = add_mod7(wk_ff, day_mod7(day_ff));
      end
      if (cmd.add_offset) begin
         serial_in = acc_ff;
         acc_in    = acc_ff + off_ext;
      end
      if (cmd.shift_year) begin
         acc_in = acc_ff - yd_ext;
      end
      if (cmd.shift_month) begin
         acc_in = acc_ff - md_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         day_ff    <= req_day_of_month;
         month_ff  <= req_month;
         year_ff   <= req_year;
         offset_ff <= req_offset_days;
      end
      yr_ff     <= yr_in;
      c100_ff   <= c100_in;
      c400_ff   <= c400_in;
      mon_ff    <= mon_in;
      acc_ff    <= acc_in;
      serial_ff <= serial_in;
      wk_ff     <= wk_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         unique case (cmd.kind)
            RES_OK: begin
               rsp_date_valid_ff    <= 1'b1;
               rsp_day_serial_ff    <= serial_ff[16:0];
               rsp_weekday_ff       <= wk_ff;
               rsp_shifted_day_ff   <= acc_ff[4:0];
               rsp_shifted_month_ff <= mon_ff;
               rsp_shifted_year_ff  <= yr_ff;
               rsp_out_of_range_ff  <= 1'b0;
            end
            RES_OUT: begin
               rsp_date_valid_ff    <= 1'b1;
               rsp_day_serial_ff    <= serial_ff[16:0];
               rsp_weekday_ff       <= wk_ff;
               rsp_shifted_day_ff   <= 5'd0;
               rsp_shifted_month_ff <= 4'd0;
               rsp_shifted_year_ff  <= 16'd0;
               rsp_out_of_range_ff  <= 1'b1;
            end
            default: begin
               rsp_date_valid_ff    <= 1'b0;
               rsp_day_serial_ff    <= 17'd0;
               rsp_weekday_ff       <= 3'd0;
               rsp_shifted_day_ff   <= 5'd0;
               rsp_shifted_month_ff <= 4'd0;
               rsp_shifted_year_ff  <= 16'd0;
               rsp_out_of_range_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_date_valid    = rsp_date_valid_ff;
   assign rsp_day_serial    = rsp_day_serial_ff;
   assign rsp_weekday       = rsp_weekday_ff;
   assign rsp_shifted_day   = rsp_shifted_day_ff;
   assign rsp_shifted_month = rsp_shifted_month_ff;
   assign rsp_shifted_year  = rsp_shifted_year_ff;
   assign rsp_out_of_range  = rsp_out_of_range_ff;

`ifndef SYNTH
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for more than one cycle");

   a_invalid_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_date_valid_ff) |->
         ((rsp_day_serial_ff == 17'd0) && !rsp_out_of_range_ff))
      else $error("invalid date transaction carried nonzero fields");
`endif

endmodule

### sv/gregorian_date_day_arithmetic.sv
// One transaction is accepted when start is high while busy is low. The result appears for
// exactly one cycle with rsp_strobe high, and the receiver cannot stall, so each result must be
// captured in its strobe cycle. Busy falls in the result cycle, so start may be accepted again
// at the edge that ends it.
// The sequencer walks the calendar one year or one month per cycle, first to the input date
// and then again to the shifted date. A valid date whose shifted date lies in the span ends
// after the walk to the shifted month. A shifted date outside the span ends at the range
// check, a day past the end of its month ends in the month scan, and any other invalid date
// ends at validation.
module gregorian_date_day_arithmetic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [4:0]         req_day_of_month,
   input  logic [3:0]         req_month,
   input  logic [15:0]        req_year,
   input  logic signed [17:0] req_offset_days,
   output logic               rsp_strobe,
   output logic               rsp_date_valid,
   output logic [16:0]        rsp_day_serial,
   output logic [2:0]         rsp_weekday,
   output logic [4:0]         rsp_shifted_day,
   output logic [3:0]         rsp_shifted_month,
   output logic [15:0]        rsp_shifted_year,
   output logic               rsp_out_of_range
);
   import gdda_pkg::*;

   cmd_type    cmd;
   status_type status;

   gdda_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   gdda_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_day_of_month  (req_day_of_month),
      .req_month         (req_month),
      .req_year          (req_year),
      .req_offset_days   (req_offset_days),
      .rsp_strobe        (rsp_strobe),
      .rsp_date_valid    (rsp_date_valid),
      .rsp_day_serial    (rsp_day_serial),
      .rsp_weekday       (rsp_weekday),
      .rsp_shifted_day   (rsp_shifted_day),
      .rsp_shifted_month (rsp_shifted_month),
      .rsp_shifted_year  (rsp_shifted_year),
      .rsp_out_of_range  (rsp_out_of_range)
   );

endmodule

### verif/gregorian_date_day_arithmetic_test.sv
`timescale 1ns / 1ps

module gregorian_date_day_arithmetic_test;
   import gdda_pkg::*;

   typedef struct {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [15:0] year;
      logic [17:0] offset;
      bit          drain_first;
   } date_query_type;

   typedef struct {
      logic        date_valid;
      logic [16:0] day_serial;
      logic [2:0]  weekday;
      logic [4:0]  shifted_day;
      logic [3:0]  shifted_month;
      logic [15:0] shifted_year;
      logic        out_of_range;
   } date_outcome_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [4:0]         req_day_of_month = '0;
   logic [3:0]         req_month = '0;
   logic [15:0]        req_year = '0;
   logic signed [17:0] req_offset_days = '0;
   logic               rsp_strobe;
   logic               rsp_date_valid;
   logic [16:0]        rsp_day_serial;
   logic [2:0]         rsp_weekday;
   logic [4:0]         rsp_shifted_day;
   logic [3:0]         rsp_shifted_month;
   logic [15:0]        rsp_shifted_year;
   logic               rsp_out_of_range;

   date_query_type   date_queries[$];
   date_outcome_type pending_outcomes[$];
   int               mismatch_count = 0;
   int               burst_left = 1;
   int               gap_left = 0;

   gregorian_date_day_arithmetic DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_day_of_month  (req_day_of_month),
      .req_month         (req_month),
      .req_year          (req_year),
      .req_offset_days   (req_offset_days),
      .rsp_strobe        (rsp_strobe),
      .rsp_date_valid    (rsp_date_valid),
      .rsp_day_serial    (rsp_day_serial),
      .rsp_weekday       (rsp_weekday),
      .rsp_shifted_day   (rsp_shifted_day),
      .rsp_shifted_month (rsp_shifted_month),
      .rsp_shifted_year  (rsp_shifted_year),
      .rsp_out_of_range  (rsp_out_of_range)
   );

   always #6 clock = ~clock;

   function automatic bit is_leap(input int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int days_in_month(input int m, input int y);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         2: return is_leap(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default: return 0;
      endcase
   endfunction

   function automatic int days_in_year(input int y);
      return is_leap(y) ? 366 : 365;
   endfunction

   function automatic int span_days();
      int total;
      total = 0;
      for (int y = BASE_YEAR; y < BASE_YEAR + YEAR_SPAN; y++) total += days_in_year(y);
      return total;
   endfunction

   function automatic date_outcome_type predict_outcome(input date_query_type q);
      date_outcome_type r;
      int last_year;
      int serial;
      int target;
      int y;
      int m;
      int shift;
      r = '{default: '0};
      last_year = BASE_YEAR + YEAR_SPAN - 1;
      if (q.year < BASE_YEAR || q.year > last_year || q.month < 1 || q.month > 12 ||
          q.day == 0 || q.day > days_in_month(int'(q.month), int'(q.year))) return r;
      serial = 0;
      for (y = BASE_YEAR; y < q.year; y++) serial += days_in_year(y);
      for (m = 1; m < q.month; m++) serial += days_in_month(m, int'(q.year));
      serial += int'(q.day);
      r.date_valid = 1'b1;
      r.day_serial = serial[16:0];
      r.weekday = 3'((serial - 1) % 7);
      shift = int'($signed(q.offset));
      target = serial + shift;
      if (target < 1 || target > span_days()) begin
         r.out_of_range = 1'b1;
         return r;
      end
      y = BASE_YEAR;
      while (target > days_in_year(y)) begin
         target -= days_in_year(y);
         y++;
      end
      m = 1;
      while (m < 12 && target > days_in_month(m, y)) begin
         target -= days_in_month(m, y);
         m++;
      end
      r.shifted_day = target[4:0];
      r.shifted_month = m[3:0];
      r.shifted_year = y[15:0];
      return r;
   endfunction

   task automatic add_query(input int d, input int m, input int y, input int off,
                            input bit drain);
      date_query_type q;
      q.day = d[4:0];
      q.month = m[3:0];
      q.year = y[15:0];
      q.offset = off[17:0];
      q.drain_first = drain;
      date_queries.push_back(q);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : driver
      date_query_type next_query;
      bit launched;
      if (reset) begin
         start <= 1'b0;
      end else begin
         launched = start && !busy;
         if (launched) begin
            pending_outcomes.push_back(predict_outcome('{req_day_of_month, req_month,
               req_year, req_offset_days, 1'b0}));
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 5) == 0) ? 80 : int'($urandom_range(1, 24));
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 40));
            end
         end
         if (!start || launched) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (date_queries.size() > 0 &&
                         (!date_queries[0].drain_first || pending_outcomes.size() == 0)) begin
               next_query = date_queries.pop_front();
               req_day_of_month <= next_query.day;
               req_month <= next_query.month;
               req_year <= next_query.year;
               req_offset_days <= next_query.offset;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      date_outcome_type want;
      if (!reset && rsp_strobe) begin
         if (pending_outcomes.size() == 0) begin
            $error("result transaction with no outstanding request");
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("date_valid", int'(want.date_valid), int'(rsp_date_valid));
            check_field("day_serial", int'(want.day_serial), int'(rsp_day_serial));
            check_field("weekday", int'(want.weekday), int'(rsp_weekday));
            check_field("shifted_day", int'(want.shifted_day), int'(rsp_shifted_day));
            check_field("shifted_month", int'(want.shifted_month), int'(rsp_shifted_month));
            check_field("shifted_year", int'(want.shifted_year), int'(rsp_shifted_year));
            check_field("out_of_range", int'(want.out_of_range), int'(rsp_out_of_range));
         end
      end
   end

   initial begin
      #(80_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      date_query_type   q;
      date_outcome_type probe;
      int total;
      int last_year;
      int serial;
      int off;
      int pick;
      total = span_days();
      last_year = BASE_YEAR + YEAR_SPAN - 1;

      add_query(1, 1, BASE_YEAR, 0, 0);
      add_query(7, 1, BASE_YEAR, 0, 0);
      add_query(31, 12, last_year, 0, 0);
      add_query(31, 12, 1904, 0, 0);
      add_query(31, 12, 2000, 0, 0);
      add_query(29, 2, 2000, 0, 0);
      add_query(29, 2, 1900, 0, 0);
      add_query(29, 2, 1904, 5, 0);
      add_query(29, 2, 1901, 0, 0);
      add_query(31, 4, 1950, 0, 0);
      add_query(0, 5, 1950, 0, 0);
      add_query(1, 0, 1950, 0, 0);
      add_query(1, 13, 1950, 0, 0);
      add_query(31, 15, 65535, -1, 0);
      add_query(1, 1, BASE_YEAR - 1, 0, 0);
      add_query(1, 1, last_year + 1, 0, 0);
      add_query(1, 1, 0, 0, 0);
      add_query(1, 1, BASE_YEAR, -1, 0);
      add_query(31, 12, last_year, 1, 0);
      add_query(1, 1, BASE_YEAR, total - 1, 0);
      add_query(31, 12, last_year, 1 - total, 0);
      add_query(15, 6, 2000, 131071, 0);
      add_query(15, 6, 2000, -131072, 0);
      add_query(31, 12, 1904, 366, 0);

      for (int n = 0; n < 1880; n++) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 8) begin
            q.day = 5'($urandom_range(0, 31));
            q.month = 4'($urandom_range(0, 15));
            q.year = 16'($urandom_range(0, 65535));
            q.offset = 18'($urandom_range(0, 18'h3FFFF));
         end else if (pick < 15) begin
            q.day = 5'($urandom_range(27, 31));
            q.month = 4'($urandom_range(0, 15));
            q.year = 16'(BASE_YEAR + $urandom_range(0, YEAR_SPAN - 1));
            q.offset = 18'($urandom_range(0, 18'h3FFFF));
         end else begin
            q.year = 16'(BASE_YEAR + $urandom_range(0, YEAR_SPAN - 1));
            q.month = 4'($urandom_range(1, 12));
            q.day = 5'($urandom_range(1, days_in_month(int'(q.month), int'(q.year))));
            q.offset = '0;
            probe = predict_outcome(q);
            serial = int'(probe.day_serial);
            case ($urandom_range(0, 9))
               0, 1, 2: off = int'($urandom_range(0, 800)) - 400;
               3, 4:    off = int'($urandom_range(0, 60000)) - 30000;
               5:       off = int'($signed(18'($urandom_range(0, 18'h3FFFF))));
               6, 7:    off = total - serial + int'($urandom_range(0, 6)) - 3;
               8:       off = 1 - serial + int'($urandom_range(0, 6)) - 3;
               default: off = int'($urandom_range(0, 2)) - 1;
            endcase
            q.offset = off[17:0];
         end
         q.drain_first = (n % 250 == 0);
         date_queries.push_back(q);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (date_queries.size() > 0 || start || pending_outcomes.size() > 0)
         @(posedge clock);
      repeat (600) @(posedge clock);

      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
